/* hw/rtl/fan_tp_pkg.sv */
// Package with the shared constants, word types and state type of the fan tachometer block.
package fan_tp_pkg;

    localparam int COUNT_BITS    = 30;
    localparam int CLOCK_BITS    = 28;
    localparam int DIVIDEND_BITS = 34;
    localparam int RPM_BITS      = 16;
    localparam int STEP_BITS     = 6;
    localparam int QUEUE_DEPTH   = 2;

    localparam logic [CLOCK_BITS-1:0] CLOCK_HZ_RESET = 28'd80000000;
    localparam logic [RPM_BITS-1:0]   RPM_MAX        = 16'hFFFF;

    typedef struct packed {
        logic                  channel;
        logic                  rising_edge;
        logic [COUNT_BITS-1:0] capture_count;
    } in_word_t;

    typedef struct packed {
        logic [COUNT_BITS-1:0] elapsed;
        logic                  rpm_valid;
        logic [RPM_BITS-1:0]   rpm;
        logic                  zero_period;
    } out_word_t;

    typedef struct packed {
        logic [COUNT_BITS-1:0] elapsed;
        logic                  tach;
        logic                  zero;
        logic [COUNT_BITS-1:0] period;
    } job_t;

    typedef enum logic [1:0] {
        BK_IDLE,
        BK_DIVIDE,
        BK_HOLD
    } back_state_t;

endpackage

/* hw/rtl/fan_tach_period_rpm.sv */
// Top level of the fan tachometer period and rpm measurement block.
//
//   Port group   Direction  Handshake          Word
//   in           input      in_valid/in_ready  in_word: channel, edge kind, capture count
//   out          output     out_valid/out_ready out_word: elapsed, rpm_valid, rpm, zero flag
//   cfg          input      cfg_wr_en          cfg_wr_data: capture clock in hertz
//
// A tachometer word that heads the queue is popped, then runs through 34 divider steps of one
// quotient bit each, then waits for the output register to be free and loads it. Other words
// skip the divider steps. The front end takes a word every cycle until the queue is full.
// Reset clears the edge history, the stored period, the queue and the output valid flag.
// The output register lets the divider start the next word while a result waits.
module fan_tach_period_rpm #(
    parameter int QUEUE_DEPTH = fan_tp_pkg::QUEUE_DEPTH
) (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              in_valid,
    output logic                              in_ready,
    input  fan_tp_pkg::in_word_t              in_word,
    output logic                              out_valid,
    input  logic                              out_ready,
    output fan_tp_pkg::out_word_t             out_word,
    input  logic                              cfg_wr_en,
    input  logic [fan_tp_pkg::CLOCK_BITS-1:0] cfg_wr_data
);

    logic             push;
    fan_tp_pkg::job_t push_job;
    logic             queue_full;
    logic             pop;
    logic             head_valid;
    fan_tp_pkg::job_t head_job;

    fan_tp_front u_front (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_valid   (in_valid),
        .in_ready   (in_ready),
        .in_word    (in_word),
        .push       (push),
        .push_job   (push_job),
        .queue_full (queue_full)
    );

    fan_tp_fifo #(
        .DEPTH (QUEUE_DEPTH)
    ) u_fifo (
        .clk        (clk),
        .rst_n      (rst_n),
        .push       (push),
        .push_job   (push_job),
        .full       (queue_full),
        .pop        (pop),
        .head_valid (head_valid),
        .head_job   (head_job)
    );

    fan_tp_back u_back (
        .clk         (clk),
        .rst_n       (rst_n),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_wr_data (cfg_wr_data),
        .head_valid  (head_valid),
        .head_job    (head_job),
        .pop         (pop),
        .out_valid   (out_valid),
        .out_ready   (out_ready),
        .out_word    (out_word)
    );

endmodule

/* hw/rtl/fan_tp_front.sv */
// Front end: accepts capture words, measures elapsed counts and queues jobs for the back end.
module fan_tp_front (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 in_valid,
    output logic                 in_ready,
    input  fan_tp_pkg::in_word_t in_word,
    output logic                 push,
    output fan_tp_pkg::job_t     push_job,
    input  logic                 queue_full
);

    logic [fan_tp_pkg::COUNT_BITS-1:0] last_count_reg [4];
    logic [fan_tp_pkg::COUNT_BITS-1:0] period_reg;
    logic [fan_tp_pkg::COUNT_BITS-1:0] period_next;
    logic [fan_tp_pkg::COUNT_BITS-1:0] elapsed;
    logic [1:0]                        idx;

    assign in_ready = !queue_full;
    assign push     = in_valid && in_ready;
    assign idx      = {in_word.channel, in_word.rising_edge};
    assign elapsed  = in_word.capture_count - last_count_reg[idx];

    always_comb
    begin
        period_next = period_reg;
        if (!in_word.channel && in_word.rising_edge)
        begin
            period_next = elapsed;
        end
        push_job.elapsed = elapsed;
        push_job.tach    = !in_word.channel;
        push_job.zero    = (period_next == '0);
        push_job.period  = period_next;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < 4; i++)
            begin
                last_count_reg[i] <= '0;
            end
            period_reg <= '0;
        end
        else if (push)
        begin
            last_count_reg[idx] <= in_word.capture_count;
            period_reg          <= period_next;
        end
    end

endmodule

/* hw/rtl/fan_tp_fifo.sv */
// Short job queue between the front end and the divider.
module fan_tp_fifo #(
    parameter int DEPTH = fan_tp_pkg::QUEUE_DEPTH
) (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             push,
    input  fan_tp_pkg::job_t push_job,
    output logic             full,
    input  logic             pop,
    output logic             head_valid,
    output fan_tp_pkg::job_t head_job
);

    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);

    fan_tp_pkg::job_t   slot_reg [DEPTH];
    logic [PTR_W-1:0]   wr_ptr_reg;
    logic [PTR_W-1:0]   rd_ptr_reg;
    logic [CNT_W-1:0]   fill_reg;

    assign full       = (fill_reg == CNT_W'(DEPTH));
    assign head_valid = (fill_reg != '0);
    assign head_job   = slot_reg[rd_ptr_reg];

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            slot_reg[wr_ptr_reg] <= push_job;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            fill_reg   <= '0;
        end
        else
        begin
            if (push)
            begin
                wr_ptr_reg <= (wr_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
            end
            if (pop)
            begin
                rd_ptr_reg <= (rd_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
            end
            if (push && !pop)
            begin
                fill_reg <= fill_reg + 1'b1;
            end
            else if (pop && !push)
            begin
                fill_reg <= fill_reg - 1'b1;
            end
        end
    end

endmodule

/* hw/rtl/fan_tp_back.sv */
// Back end: holds the clock register, runs the bit-serial rpm division and drives the result word.
module fan_tp_back (
    input  logic                                  clk,
    input  logic                                  rst_n,
    input  logic                                  cfg_wr_en,
    input  logic [fan_tp_pkg::CLOCK_BITS-1:0]     cfg_wr_data,
    input  logic                                  head_valid,
    input  fan_tp_pkg::job_t                      head_job,
    output logic                                  pop,
    output logic                                  out_valid,
    input  logic                                  out_ready,
    output fan_tp_pkg::out_word_t                 out_word
);

    localparam int CB = fan_tp_pkg::COUNT_BITS;
    localparam int DB = fan_tp_pkg::DIVIDEND_BITS;
    localparam int RB = fan_tp_pkg::RPM_BITS;
    localparam int SB = fan_tp_pkg::STEP_BITS;

    fan_tp_pkg::back_state_t state_reg, state_next;

    logic [fan_tp_pkg::CLOCK_BITS-1:0] clk_hz_reg;
    logic [CB-1:0] rem_reg, rem_next;
    logic [DB-1:0] quo_reg, quo_next;
    logic [CB-1:0] div_reg, div_next;
    logic [SB-1:0] step_reg, step_next;
    logic [CB-1:0] elapsed_reg, elapsed_next;
    logic          tach_reg, tach_next;
    logic          zero_reg, zero_next;
    logic [RB-1:0] rpm_reg, rpm_next;
    logic          out_valid_reg, out_valid_next;
    fan_tp_pkg::out_word_t out_word_reg, out_word_next;

    logic [DB-1:0] dividend;
    logic [CB:0]   trial;
    logic [CB:0]   diff;
    logic          fits;

    assign dividend = {clk_hz_reg, 6'b0} - {4'b0, clk_hz_reg, 2'b0};
    assign trial    = {rem_reg, quo_reg[DB-1]};
    assign diff     = trial - {1'b0, div_reg};
    assign fits     = (trial >= {1'b0, div_reg});

    assign out_valid = out_valid_reg;
    assign out_word  = out_word_reg;

    always_comb
    begin
        state_next     = state_reg;
        rem_next       = rem_reg;
        quo_next       = quo_reg;
        div_next       = div_reg;
        step_next      = step_reg;
        elapsed_next   = elapsed_reg;
        tach_next      = tach_reg;
        zero_next      = zero_reg;
        rpm_next       = rpm_reg;
        out_valid_next = out_valid_reg && !out_ready;
        out_word_next  = out_word_reg;
        pop            = 1'b0;
        case (state_reg)
            fan_tp_pkg::BK_IDLE:
            begin
                if (head_valid)
                begin
                    pop          = 1'b1;
                    elapsed_next = head_job.elapsed;
                    tach_next    = head_job.tach;
                    zero_next    = head_job.zero;
                    div_next     = head_job.period;
                    if (head_job.tach && !head_job.zero)
                    begin
                        rem_next   = '0;
                        quo_next   = dividend;
                        step_next  = '0;
                        state_next = fan_tp_pkg::BK_DIVIDE;
                    end
                    else
                    begin
                        rpm_next   = head_job.tach ? fan_tp_pkg::RPM_MAX : '0;
                        state_next = fan_tp_pkg::BK_HOLD;
                    end
                end
            end
            fan_tp_pkg::BK_DIVIDE:
            begin
                rem_next  = fits ? diff[CB-1:0] : trial[CB-1:0];
                quo_next  = {quo_reg[DB-2:0], fits};
                step_next = step_reg + 1'b1;
                if (step_reg == SB'(DB - 1))
                begin
                    rpm_next   = (quo_next[DB-1:RB] != '0) ? fan_tp_pkg::RPM_MAX
                                                           : quo_next[RB-1:0];
                    state_next = fan_tp_pkg::BK_HOLD;
                end
            end
            fan_tp_pkg::BK_HOLD:
            begin
                if (!out_valid_reg || out_ready)
                begin
                    out_valid_next            = 1'b1;
                    out_word_next.elapsed     = elapsed_reg;
                    out_word_next.rpm_valid   = tach_reg;
                    out_word_next.rpm         = rpm_reg;
                    out_word_next.zero_period = tach_reg && zero_reg;
                    state_next                = fan_tp_pkg::BK_IDLE;
                end
            end
            default:
            begin
                state_next = fan_tp_pkg::BK_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= fan_tp_pkg::BK_IDLE;
            clk_hz_reg    <= fan_tp_pkg::CLOCK_HZ_RESET;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
            if (cfg_wr_en)
            begin
                clk_hz_reg <= cfg_wr_data;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        rem_reg      <= rem_next;
        quo_reg      <= quo_next;
        div_reg      <= div_next;
        step_reg     <= step_next;
        elapsed_reg  <= elapsed_next;
        tach_reg     <= tach_next;
        zero_reg     <= zero_next;
        rpm_reg      <= rpm_next;
        out_word_reg <= out_word_next;
    end

endmodule

/* test/testbench.sv */
// Self-checking testbench for the fan tachometer period and rpm block.
`timescale 1ns / 1ps

module testbench;

    localparam logic CH_TACH   = 1'b0;
    localparam logic CH_PWM    = 1'b1;
    localparam logic EDGE_FALL = 1'b0;
    localparam logic EDGE_RISE = 1'b1;

    localparam int CYCLE_LIMIT   = 600000;
    localparam int SETTLE_CYCLES = 60;
    localparam int CHUNK_WORDS   = 150;
    localparam int NUM_CHUNKS    = 6;
    localparam int NUM_PROBES    = 18;

    typedef struct {
        logic                              chan;
        logic                              rise;
        logic [fan_tp_pkg::COUNT_BITS-1:0] count;
        bit                                known;
        fan_tp_pkg::out_word_t             want;
    } probe_row_t;

    logic                              clk = 1'b0;
    logic                              rst_n = 1'b0;
    logic                              in_valid = 1'b0;
    logic                              in_ready;
    fan_tp_pkg::in_word_t              in_word = '0;
    logic                              out_valid;
    logic                              out_ready = 1'b0;
    fan_tp_pkg::out_word_t             out_word;
    logic                              cfg_wr_en = 1'b0;
    logic [fan_tp_pkg::CLOCK_BITS-1:0] cfg_wr_data = '0;

    logic [fan_tp_pkg::CLOCK_BITS-1:0] model_clock_hz;
    logic [fan_tp_pkg::COUNT_BITS-1:0] model_last [4];
    logic [fan_tp_pkg::COUNT_BITS-1:0] model_period;
    logic [fan_tp_pkg::COUNT_BITS-1:0] gen_last [4];

    fan_tp_pkg::out_word_t pending_q [$];
    int send_idle_pct = 0;
    int recv_idle_pct = 0;
    int fail_count = 0;
    int words_sent = 0;
    int tach_seen = 0;
    int sat_seen = 0;
    int zero_seen = 0;
    int cycle_count = 0;

    probe_row_t probe_rows [NUM_PROBES] = '{
        '{CH_TACH, EDGE_FALL, 30'd0,        1'b1, '{30'd0, 1'b1, fan_tp_pkg::RPM_MAX, 1'b1}},
        '{CH_TACH, EDGE_RISE, 30'd0,        1'b1, '{30'd0, 1'b1, fan_tp_pkg::RPM_MAX, 1'b1}},
        '{CH_TACH, EDGE_RISE, 30'd1,        1'b1, '{30'd1, 1'b1, fan_tp_pkg::RPM_MAX, 1'b0}},
        '{CH_PWM,  EDGE_RISE, 30'h3FFFFFFF, 1'b1, '{30'h3FFFFFFF, 1'b0, 16'd0, 1'b0}},
        '{CH_PWM,  EDGE_RISE, 30'd5,        1'b1, '{30'd6, 1'b0, 16'd0, 1'b0}},
        '{CH_PWM,  EDGE_FALL, 30'h3FFFFFFF, 1'b1, '{30'h3FFFFFFF, 1'b0, 16'd0, 1'b0}},
        '{CH_TACH, EDGE_RISE, 30'h3FFFFFFF, 1'b0, '0},
        '{CH_TACH, EDGE_FALL, 30'h2AAAAAAA, 1'b0, '0},
        '{CH_TACH, EDGE_RISE, 30'd0,        1'b1, '{30'd1, 1'b1, fan_tp_pkg::RPM_MAX, 1'b0}},
        '{CH_TACH, EDGE_RISE, 30'd73242,    1'b0, '0},
        '{CH_TACH, EDGE_RISE, 30'd146485,   1'b0, '0},
        '{CH_TACH, EDGE_RISE, 30'd219729,   1'b0, '0},
        '{CH_TACH, EDGE_RISE, 30'd2219729,  1'b0, '0},
        '{CH_PWM,  EDGE_FALL, 30'h15555555, 1'b0, '0},
        '{CH_TACH, EDGE_FALL, 30'h2AAAAAAA, 1'b0, '0},
        '{CH_TACH, EDGE_RISE, 30'd2219729,  1'b1, '{30'd0, 1'b1, fan_tp_pkg::RPM_MAX, 1'b1}},
        '{CH_PWM,  EDGE_FALL, 30'd0,        1'b0, '0},
        '{CH_TACH, EDGE_FALL, 30'd5,        1'b0, '0}
    };

    fan_tach_period_rpm dut (
        .clk         (clk),
        .rst_n       (rst_n),
        .in_valid    (in_valid),
        .in_ready    (in_ready),
        .in_word     (in_word),
        .out_valid   (out_valid),
        .out_ready   (out_ready),
        .out_word    (out_word),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_wr_data (cfg_wr_data)
    );

    initial
    begin
        forever
        begin
            #5 clk = ~clk;
        end
    end

    function automatic fan_tp_pkg::out_word_t predict_speed(input fan_tp_pkg::in_word_t w);
        fan_tp_pkg::out_word_t r;
        logic [1:0]            pair;
        longint unsigned       quotient;
        pair = {w.channel, w.rising_edge};
        r = '0;
        r.elapsed = w.capture_count - model_last[pair];
        model_last[pair] = w.capture_count;
        if (w.channel == CH_TACH)
        begin
            if (w.rising_edge == EDGE_RISE)
                model_period = r.elapsed;
            r.rpm_valid = 1'b1;
            if (model_period == '0)
            begin
                r.zero_period = 1'b1;
                r.rpm = fan_tp_pkg::RPM_MAX;
            end
            else
            begin
                quotient = (64'd60 * 64'(model_clock_hz)) / 64'(model_period);
                r.rpm = (quotient > 64'(fan_tp_pkg::RPM_MAX)) ? fan_tp_pkg::RPM_MAX
                                                               : quotient[fan_tp_pkg::RPM_BITS-1:0];
            end
        end
        return r;
    endfunction

    task automatic send_capture(input fan_tp_pkg::in_word_t w, input bit known,
                                input fan_tp_pkg::out_word_t want);
        fan_tp_pkg::out_word_t predicted;
        while ($urandom_range(99) < send_idle_pct)
        begin
            in_valid <= 1'b0;
            @(posedge clk);
        end
        in_valid <= 1'b1;
        in_word  <= w;
        @(posedge clk);
        while (!in_ready)
            @(posedge clk);
        predicted = predict_speed(w);
        pending_q.push_back(known ? want : predicted);
        words_sent++;
    endtask

    task automatic drain_results();
        in_valid <= 1'b0;
        while (pending_q.size() != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    task automatic write_clock(input logic [fan_tp_pkg::CLOCK_BITS-1:0] hz);
        drain_results();
        cfg_wr_en   <= 1'b1;
        cfg_wr_data <= hz;
        @(posedge clk);
        cfg_wr_en <= 1'b0;
        model_clock_hz = hz;
    endtask

    function automatic logic [fan_tp_pkg::COUNT_BITS-1:0] pick_delta();
        int              pick;
        longint unsigned knee;
        pick = $urandom_range(99);
        knee = (64'd60 * 64'(model_clock_hz)) / 64'd65536;
        if (pick < 5)
            return '0;
        else if (pick < 15)
            return fan_tp_pkg::COUNT_BITS'($urandom_range(100, 1));
        else if (pick < 25)
            return fan_tp_pkg::COUNT_BITS'(knee + 64'($urandom_range(3)));
        else if (pick < 35)
            return fan_tp_pkg::COUNT_BITS'($urandom_range(32'h3FFFFFFF, 32'h3F000000));
        else if (pick < 40)
            return fan_tp_pkg::COUNT_BITS'($urandom());
        else
            return fan_tp_pkg::COUNT_BITS'($urandom_range(20000000, 20000));
    endfunction

    function automatic fan_tp_pkg::in_word_t make_capture();
        fan_tp_pkg::in_word_t w;
        logic [1:0]           pair;
        w.channel = ($urandom_range(3) == 0) ? CH_PWM : CH_TACH;
        w.rising_edge = ($urandom_range(99) < 65) ? EDGE_RISE : EDGE_FALL;
        pair = {w.channel, w.rising_edge};
        if ($urandom_range(99) < 10)
            w.capture_count = fan_tp_pkg::COUNT_BITS'($urandom());
        else
            w.capture_count = gen_last[pair] + pick_delta();
        gen_last[pair] = w.capture_count;
        return w;
    endfunction

    always @(posedge clk)
    begin
        fan_tp_pkg::out_word_t want;
        if (rst_n && out_valid && out_ready)
        begin
            if (pending_q.size() == 0)
            begin
                $error("result word with nothing expected: elapsed %0h rpm %0d",
                       out_word.elapsed, out_word.rpm);
                fail_count++;
            end
            else
            begin
                want = pending_q.pop_front();
                if (out_word.elapsed !== want.elapsed)
                begin
                    $error("elapsed: expected %0h, actual %0h", want.elapsed, out_word.elapsed);
                    fail_count++;
                end
                if (out_word.rpm_valid !== want.rpm_valid)
                begin
                    $error("rpm_valid: expected %0b, actual %0b",
                           want.rpm_valid, out_word.rpm_valid);
                    fail_count++;
                end
                if (out_word.rpm !== want.rpm)
                begin
                    $error("rpm: expected %0d, actual %0d", want.rpm, out_word.rpm);
                    fail_count++;
                end
                if (out_word.zero_period !== want.zero_period)
                begin
                    $error("zero_period: expected %0b, actual %0b",
                           want.zero_period, out_word.zero_period);
                    fail_count++;
                end
                if (want.rpm_valid)
                    tach_seen++;
                if (want.rpm_valid && want.rpm == fan_tp_pkg::RPM_MAX && !want.zero_period)
                    sat_seen++;
                if (want.zero_period)
                    zero_seen++;
            end
        end
        out_ready <= rst_n && ($urandom_range(99) >= recv_idle_pct);
    end

    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count == CYCLE_LIMIT)
        begin
            $display("SCOREBOARD MISMATCH");
            $finish;
        end
    end

    initial
    begin
        logic [fan_tp_pkg::CLOCK_BITS-1:0] chunk_clock [NUM_CHUNKS];
        fan_tp_pkg::in_word_t              w;
        chunk_clock = '{28'd1000000, 28'd160000000, 28'd0, 28'hFFFFFFF,
                        fan_tp_pkg::CLOCK_BITS'($urandom_range(160000000, 1000000)),
                        fan_tp_pkg::CLOCK_HZ_RESET};
        model_clock_hz = fan_tp_pkg::CLOCK_HZ_RESET;
        model_period = '0;
        for (int i = 0; i < 4; i++)
        begin
            model_last[i] = '0;
            gen_last[i] = '0;
        end
        repeat (2) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        foreach (probe_rows[i])
        begin
            w.channel       = probe_rows[i].chan;
            w.rising_edge   = probe_rows[i].rise;
            w.capture_count = probe_rows[i].count;
            send_capture(w, probe_rows[i].known, probe_rows[i].want);
            gen_last[{w.channel, w.rising_edge}] = w.capture_count;
        end

        for (int c = 0; c < NUM_CHUNKS; c++)
        begin
            write_clock(chunk_clock[c]);
            if (c < 2)
            begin
                send_idle_pct = 23;
                recv_idle_pct = 81;
            end
            else if (c < 4)
            begin
                send_idle_pct = 81;
                recv_idle_pct = 23;
            end
            else
            begin
                send_idle_pct = 0;
                recv_idle_pct = 0;
            end
            for (int n = 0; n < CHUNK_WORDS; n++)
            begin
                w = make_capture();
                send_capture(w, 1'b0, '0);
            end
        end

        drain_results();
        $display("Sent %0d capture words under %0d clock settings with three idling patterns.",
                 words_sent, NUM_CHUNKS + 1);
        $display("%0d tachometer results, %0d saturated, %0d with a zero period.",
                 tach_seen, sat_seen, zero_seen);
        if (fail_count == 0 && pending_q.size() == 0)
            $display("SCOREBOARD CLEAN");
        else
            $display("SCOREBOARD MISMATCH");
        $finish;
    end

endmodule

/* sim.f */
hw/rtl/fan_tp_pkg.sv
hw/rtl/fan_tp_front.sv
hw/rtl/fan_tp_fifo.sv
hw/rtl/fan_tp_back.sv
hw/rtl/fan_tach_period_rpm.sv
test/testbench.sv
